// ===== rtl/core/dft_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the decimal Fibonacci term generator.
// Used by the controller, the datapath and the top level; depends on nothing.
package dft_pkg;

  localparam int unsigned INDEX_W     = 10;  // width of the term index field
  localparam int unsigned DIGIT_W     = 4;   // one BCD digit
  localparam int unsigned POS_FIELD_W = 6;   // width of the digit position field
  localparam int unsigned TDATA_W     = 16;  // stream data width, whole bytes
  localparam logic [3:0]  DEC_BASE    = 4'd10;
  localparam logic [3:0]  DEC_MAX     = 4'd9;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // load start values and the step count from the index
    logic step;     // one add-and-shift of the digit registers
    logic advance;  // move on to the next output digit
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic steps_zero;  // no add-and-shift steps remain
    logic last_pos;    // the output digit is the most significant one
  } dp_status_t;

endpackage

// ===== rtl/core/dft_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine of the decimal Fibonacci term generator.
// Depends on dft_pkg for the state, command and status types.
module dft_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output dft_pkg::dp_cmd_t    cmd,
  input  dft_pkg::dp_status_t status
);
  import dft_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd         = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_ADD;
        end
      end
      ST_ADD: begin
        if (status.steps_zero) begin
          state_next = ST_EMIT;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.advance = 1'b1;
          if (status.last_pos) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/dft_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the decimal Fibonacci term generator: two BCD digit registers,
// a carry-lookahead decimal adder, the step counter and the output digit pointer.
// Depends on dft_pkg for widths and the command and status types.
module dft_datapath #(
  parameter int unsigned DIGIT_COUNT = 63
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [dft_pkg::INDEX_W-1:0]       term_index,
  input  dft_pkg::dp_cmd_t                  cmd,
  output dft_pkg::dp_status_t               status,
  output logic [dft_pkg::DIGIT_W-1:0]       digit,
  output logic [dft_pkg::POS_FIELD_W-1:0]   digit_position,
  output logic                              last_digit
);
  import dft_pkg::*;

  localparam int unsigned POS_W = $clog2(DIGIT_COUNT);

  logic [DIGIT_COUNT-1:0][DIGIT_W-1:0] older, newer, sum_digits;
  logic [DIGIT_COUNT-1:0][DIGIT_W-1:0] start_newer;
  logic [INDEX_W-1:0]                  steps_left;
  logic [POS_W-1:0]                    pos;

  logic [DIGIT_COUNT-1:0][DIGIT_W:0]   raw;
  logic [DIGIT_COUNT-1:0]              gen, prop, carry_in;

  // Per digit, a carry is generated when the raw sum reaches ten and
  // propagated when it is exactly nine. The carries into all digits then
  // come out of one binary add of the generate vector and the combined
  // generate-or-propagate vector.
  always_comb begin
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      raw[i]  = {1'b0, older[i]} + {1'b0, newer[i]};
      gen[i]  = (raw[i] >= {1'b0, DEC_BASE});
      prop[i] = (raw[i] == {1'b0, DEC_MAX});
    end
    carry_in = (gen + (gen | prop)) ^ gen ^ (gen | prop);
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      if ((raw[i] + {{DIGIT_W{1'b0}}, carry_in[i]}) >= {1'b0, DEC_BASE}) begin
        sum_digits[i] = DIGIT_W'(raw[i] + {{DIGIT_W{1'b0}}, carry_in[i]}
                                - {1'b0, DEC_BASE});
      end else begin
        sum_digits[i] = DIGIT_W'(raw[i] + {{DIGIT_W{1'b0}}, carry_in[i]});
      end
    end
  end

  // Index zero and one leave the newer register all zero, so no step runs
  // and the emitted value is zero.
  always_comb begin
    start_newer    = '0;
    start_newer[0] = DIGIT_W'(term_index >= INDEX_W'(2));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps_left <= '0;
      pos        <= '0;
    end else if (cmd.load) begin
      steps_left <= (term_index > INDEX_W'(2)) ? term_index - INDEX_W'(2) : '0;
      pos        <= '0;
    end else begin
      if (cmd.step) begin
        steps_left <= steps_left - INDEX_W'(1);
      end
      if (cmd.advance) begin
        pos <= (pos == POS_W'(DIGIT_COUNT - 1)) ? '0 : pos + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      older <= '0;
      newer <= start_newer;
    end else if (cmd.step) begin
      older <= newer;
      newer <= sum_digits;
    end
  end

  assign status.steps_zero = (steps_left == '0);
  assign status.last_pos   = (pos == POS_W'(DIGIT_COUNT - 1));

  assign digit          = newer[pos];
  assign digit_position = POS_FIELD_W'(pos);
  assign last_digit     = status.last_pos;

endmodule

// ===== rtl/core/decimal_fibonacci_term_top.sv =====
`timescale 1ns / 1ps
// Top level of the decimal Fibonacci term generator.
// Instantiates dft_ctrl and dft_datapath; depends on dft_pkg.
//
//   Channel   Direction  Transfer carries
//   s_axis    in         term index n (one transfer per request)
//   m_axis    out        one decimal digit per transfer, least significant first
//
// An accepted index is loaded, then runs max(n-2, 0) add-and-shift steps
// (one full-width decimal addition each, on the single shared adder), then
// leaves the add loop and gives DIGIT_COUNT output transfers.
// Reset clears the controller and the counters; the digit registers are
// reloaded with every request. While digits are being produced or emitted no
// new index is accepted; output stalls simply hold the current digit.
module decimal_fibonacci_term_top #(
  parameter int unsigned DIGIT_COUNT = 63
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [9:0] term_index, [15:10] zero
  input  logic [dft_pkg::TDATA_W-1:0]  s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [3:0] digit, [9:4] digit_position, [15:10] zero
  output logic [dft_pkg::TDATA_W-1:0]  m_axis_tdata,
  output logic                         m_axis_tlast
);
  import dft_pkg::*;

  dp_cmd_t                cmd;
  dp_status_t             status;
  logic [DIGIT_W-1:0]     digit;
  logic [POS_FIELD_W-1:0] digit_position;

  dft_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .status    (status)
  );

  dft_datapath #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .term_index     (s_axis_tdata[INDEX_W-1:0]),
    .cmd            (cmd),
    .status         (status),
    .digit          (digit),
    .digit_position (digit_position),
    .last_digit     (m_axis_tlast)
  );

  // The payload is read straight from the datapath registers, which hold
  // still while the downstream side stalls.
  assign m_axis_tdata = {{(TDATA_W - DIGIT_W - POS_FIELD_W){1'b0}}, digit_position, digit};

  // Input and output never overlap: a request is worked off before the next.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input accepted while digits are being emitted");

  // The last flag sits on the top digit position.
  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |->
      (digit_position == POS_FIELD_W'(DIGIT_COUNT - 1)))
    else $error("last flag on the wrong digit position");

  // Every emitted digit is a valid decimal digit.
  a_bcd_digit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (digit <= DEC_MAX))
    else $error("digit out of decimal range");

  // After a digit transfer that is not the last, the next digit follows
  // at the next position.
  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
      (m_axis_tvalid && (digit_position == $past(digit_position) + POS_FIELD_W'(1))))
    else $error("digit sequence broken");

endmodule
